FILE: src/query_string_percent_decoder_defines.svh
// Assertion helpers for the query string decoder.
// All checks sample on the rising edge of clk and are off during reset.
`ifndef QUERY_STRING_PERCENT_DECODER_DEFINES_SVH
`define QUERY_STRING_PERCENT_DECODER_DEFINES_SVH

// Condition must never hold.
`define QSPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define QSPD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/qspd_pkg.sv
`default_nettype none

package qspd_pkg;

  // Width of the source offset counter
  localparam int OFFSET_BITS  = 16;
  // Width of the reported error offset
  localparam int ERR_OFF_BITS = 16;

  typedef logic [OFFSET_BITS-1:0]  offset_t;
  typedef logic [ERR_OFF_BITS-1:0] err_off_t;

  // Result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_PAIR  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error kinds
  localparam logic ERR_PERCENT = 1'b0;
  localparam logic ERR_UTF8    = 1'b1;

  // Result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One result transaction
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       error_kind;
    err_off_t   err_offset;
    logic       last;
  } result_t;

  // Core status seen by the top level
  typedef struct packed {
    logic discarding;
  } core_status_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               room;
  } fifo_status_t;

endpackage

`default_nettype wire

FILE: src/qspd_in_reg.sv
`default_nettype none

// Input register: holds one raw byte until the core steps on it.
module qspd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       frame_end,
  input  wire logic       take,
  output logic            held_valid,
  output logic [7:0]      held_byte,
  output logic            held_end
);

  // Room when empty or when the held byte leaves this cycle
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= data_byte;
      held_end  <= frame_end;
    end
  end

endmodule

`default_nettype wire

FILE: src/qspd_core.sv
`default_nettype none

// Decoder step: splits pairs, undoes escapes, tracks UTF-8 and builds up to
// two results for each raw byte.
module qspd_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             form_mode,
  input  wire logic             step,
  input  wire logic [7:0]       data_byte,
  input  wire logic             frame_end,
  output logic [1:0]            res_n,
  output qspd_pkg::result_t     res0,
  output qspd_pkg::result_t     res1,
  output qspd_pkg::core_status_t status
);

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  // Limits on the second byte of a multi-byte sequence
  localparam logic [2:0] CLS_ANY   = 3'd0;
  localparam logic [2:0] CLS_A0_BF = 3'd1;
  localparam logic [2:0] CLS_80_9F = 3'd2;
  localparam logic [2:0] CLS_90_BF = 3'd3;
  localparam logic [2:0] CLS_80_8F = 3'd4;

  typedef struct packed {
    logic [1:0]        rem;
    logic [2:0]        cls;
    qspd_pkg::offset_t seq_start;
    logic              pend;
    qspd_pkg::offset_t err_at;
  } utf_state_t;

  typedef struct packed {
    qspd_pkg::offset_t position;
    logic              in_value;
    logic [1:0]        esc_phase;
    qspd_pkg::offset_t esc_start;
    logic [3:0]        high_nibble;
    logic              high_ok;
    utf_state_t        utf;
    logic              discarding;
  } core_state_t;

  function automatic qspd_pkg::offset_t sat_inc(input qspd_pkg::offset_t v);
    qspd_pkg::offset_t r;
    if (v == '1) r = v;
    else         r = v + qspd_pkg::offset_t'(1);
    return r;
  endfunction

  // {valid, value} of one hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]})      r = {1'b1, 4'(c - 8'h30)};
    else if (c inside {[8'h61:8'h66]}) r = {1'b1, 4'(c - 8'h57)};
    else if (c inside {[8'h41:8'h46]}) r = {1'b1, 4'(c - 8'h37)};
    else                               r = 5'd0;
    return r;
  endfunction

  // Feed one decoded byte into the UTF-8 checker
  function automatic utf_state_t utf_feed(input utf_state_t s, input logic [7:0] d,
                                          input qspd_pkg::offset_t src);
    utf_state_t r;
    logic [7:0] lo;
    logic [7:0] hi;
    r  = s;
    lo = 8'h80;
    hi = 8'hBF;
    case (s.cls)
      CLS_A0_BF: lo = 8'hA0;
      CLS_80_9F: hi = 8'h9F;
      CLS_90_BF: lo = 8'h90;
      CLS_80_8F: hi = 8'h8F;
      default: begin
      end
    endcase
    if (s.pend) begin
      r = s;
    end else if (s.rem != 2'd0) begin
      if (d >= lo && d <= hi) begin
        r.rem = s.rem - 2'd1;
        r.cls = CLS_ANY;
      end else begin
        r.pend   = 1'b1;
        r.err_at = s.seq_start;
      end
    end else begin
      r.seq_start = src;
      r.cls       = CLS_ANY;
      if (d < 8'h80) begin
        r.rem = 2'd0;
      end else if (d inside {[8'hC2:8'hDF]}) begin
        r.rem = 2'd1;
      end else if (d inside {[8'hE0:8'hEF]}) begin
        r.rem = 2'd2;
        if (d == 8'hE0)      r.cls = CLS_A0_BF;
        else if (d == 8'hED) r.cls = CLS_80_9F;
      end else if (d inside {[8'hF0:8'hF4]}) begin
        r.rem = 2'd3;
        if (d == 8'hF0)      r.cls = CLS_90_BF;
        else if (d == 8'hF4) r.cls = CLS_80_8F;
      end else begin
        r.pend   = 1'b1;
        r.err_at = src;
      end
    end
    return r;
  endfunction

  core_state_t st;
  core_state_t st_next;

  logic              is_amp;
  logic              is_eq;
  logic              is_data;
  logic [4:0]        hx;
  core_state_t       a;
  logic              d_emit;
  logic [7:0]        d_byte;
  logic              d_bad;
  qspd_pkg::offset_t d_err_off;
  logic              need_ec;
  logic              ec_bad;
  logic              ec_kind;
  qspd_pkg::offset_t ec_off;
  logic              bad;
  qspd_pkg::result_t r_end;
  logic              r_end_valid;

  assign status.discarding = st.discarding;

  always_comb begin
    is_amp  = (data_byte == CH_AMP);
    is_eq   = (data_byte == CH_EQ) && !st.in_value;
    is_data = !is_amp && !is_eq;
    hx      = hex_decode(data_byte);

    // Data byte handling on a copy of the state
    a         = st;
    d_emit    = 1'b0;
    d_byte    = data_byte;
    d_bad     = 1'b0;
    d_err_off = '0;
    if (is_data) begin
      case (st.esc_phase)
        ESC_HIGH: begin
          a.high_ok     = hx[4];
          a.high_nibble = hx[4] ? hx[3:0] : 4'd0;
          a.esc_phase   = ESC_LOW;
        end
        ESC_LOW: begin
          if (!st.high_ok) begin
            d_bad     = 1'b1;
            d_err_off = sat_inc(st.esc_start);
          end else if (!hx[4]) begin
            d_bad     = 1'b1;
            d_err_off = st.position;
          end else begin
            d_byte      = {st.high_nibble, hx[3:0]};
            d_emit      = 1'b1;
            a.esc_phase = ESC_IDLE;
            a.utf       = utf_feed(st.utf, {st.high_nibble, hx[3:0]}, st.esc_start);
          end
        end
        default: begin
          if (data_byte == CH_PERCENT) begin
            a.esc_phase = ESC_HIGH;
            a.esc_start = st.position;
          end else begin
            if (form_mode && data_byte == CH_PLUS) d_byte = CH_SPACE;
            d_emit = 1'b1;
            a.utf  = utf_feed(st.utf, d_byte, st.position);
          end
        end
      endcase
    end

    // End of component check: escape first, then UTF-8
    ec_bad  = (a.esc_phase != ESC_IDLE) || a.utf.pend || (a.utf.rem != 2'd0);
    ec_kind = (a.esc_phase != ESC_IDLE) ? qspd_pkg::ERR_PERCENT : qspd_pkg::ERR_UTF8;
    if (a.esc_phase != ESC_IDLE) ec_off = a.esc_start;
    else if (a.utf.pend)         ec_off = a.utf.err_at;
    else                         ec_off = a.utf.seq_start;

    need_ec = is_amp || is_eq || (is_data && !d_bad && frame_end);
    bad     = d_bad || (need_ec && ec_bad);

    // Result that closes the component, if any
    r_end       = '0;
    r_end_valid = 1'b0;
    if (need_ec) begin
      if (ec_bad) begin
        r_end.kind       = qspd_pkg::KIND_ERROR;
        r_end.error_kind = ec_kind;
        r_end.err_offset = qspd_pkg::ERR_OFF_BITS'(ec_off);
        r_end_valid      = 1'b1;
      end else if (is_amp || frame_end) begin
        r_end.kind  = qspd_pkg::KIND_PAIR;
        r_end_valid = 1'b1;
      end
    end

    // Assemble results
    res0  = '0;
    res1  = '0;
    res_n = 2'd0;
    if (d_bad) begin
      res0.kind       = qspd_pkg::KIND_ERROR;
      res0.error_kind = qspd_pkg::ERR_PERCENT;
      res0.err_offset = qspd_pkg::ERR_OFF_BITS'(d_err_off);
      res_n           = 2'd1;
    end else begin
      if (d_emit) begin
        res0.kind = st.in_value ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_NAME;
        res0.data = d_byte;
        res_n     = 2'd1;
      end
      if (r_end_valid) begin
        if (res_n == 2'd0) res0 = r_end;
        else               res1 = r_end;
        res_n = res_n + 2'd1;
      end
    end
    if (bad || frame_end) begin
      if (res_n == 2'd2)      res1.last = 1'b1;
      else if (res_n == 2'd1) res0.last = 1'b1;
    end
    if (st.discarding) res_n = 2'd0;

    // State update
    st_next = st;
    if (step) begin
      if (frame_end) begin
        st_next = '0;
      end else if (st.discarding) begin
        st_next = st;
      end else if (bad) begin
        st_next.discarding = 1'b1;
      end else begin
        if (is_data) begin
          st_next = a;
        end else begin
          st_next             = '0;
          st_next.in_value    = is_eq;
        end
        st_next.position   = sat_inc(st.position);
        st_next.discarding = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/qspd_out_fifo.sv
`default_nettype none

// Result queue: takes up to two results a cycle, hands out one.
module qspd_out_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         push_n,
  input  wire qspd_pkg::result_t  push0,
  input  wire qspd_pkg::result_t  push1,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output qspd_pkg::result_t       head,
  output qspd_pkg::fifo_status_t  status
);

  qspd_pkg::result_t mem [qspd_pkg::FIFO_DEPTH];

  logic [qspd_pkg::FIFO_AW-1:0] wr_ptr;
  logic [qspd_pkg::FIFO_AW-1:0] rd_ptr;
  logic [qspd_pkg::FIFO_CW-1:0] count;
  logic                         pop;

  assign out_valid     = (count != '0);
  assign pop           = out_valid && out_ready;
  assign head          = mem[rd_ptr];
  assign status.count  = count;
  // Room for a worst-case step of two results
  assign status.room   = (count <= qspd_pkg::FIFO_CW'(qspd_pkg::FIFO_DEPTH - 2));

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + qspd_pkg::FIFO_AW'(push_n);
      if (pop) rd_ptr <= rd_ptr + qspd_pkg::FIFO_AW'(1);
      count  <= count + qspd_pkg::FIFO_CW'(push_n) - qspd_pkg::FIFO_CW'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr] <= push0;
    if (push_n == 2'd2) mem[wr_ptr + qspd_pkg::FIFO_AW'(1)] <= push1;
  end

endmodule

`default_nettype wire

FILE: src/query_string_percent_decoder.sv
`default_nettype none
// Channel  | Signals                                      | Handshake
// ---------+----------------------------------------------+------------------
// in       | data_byte, frame_end                         | in_valid/in_ready
// out      | kind, out_byte, error_kind, err_offset, last | out_valid/out_ready
// config   | cfg_data (form_mode)                         | cfg_write
//
// One raw byte per cycle while the queue has room: a byte is held in the input
// register, the decode step runs on it and pushes its results into a four-entry queue.
// A byte's first result reaches the output through the input register and the queue.
// A byte that yields two results costs an extra output transfer; the queue
// absorbs it and in_ready drops only when fewer than two entries are free.
// Synchronous reset clears all decoder state, the queue and form_mode.
// A stalled output holds the head result; input stops below two free entries.
`include "query_string_percent_decoder_defines.svh"

module query_string_percent_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic             error_kind,
  output logic [15:0]      err_offset,
  output logic             last
);

  logic                   form_mode;
  logic                   held_valid;
  logic [7:0]             held_byte;
  logic                   held_end;
  logic                   take;
  logic [1:0]             res_n;
  logic [1:0]             push_n;
  qspd_pkg::result_t      res0;
  qspd_pkg::result_t      res1;
  qspd_pkg::result_t      head;
  qspd_pkg::core_status_t core_st;
  qspd_pkg::fifo_status_t fifo_st;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      form_mode <= 1'b0;
    end else if (cfg_write) begin
      form_mode <= cfg_data;
    end
  end

  // Step when a byte is held and the queue can take two results
  assign take   = held_valid && fifo_st.room;
  assign push_n = take ? res_n : 2'd0;

  qspd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_end   (held_end)
  );

  qspd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .form_mode (form_mode),
    .step      (take),
    .data_byte (held_byte),
    .frame_end (held_end),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1),
    .status    (core_st)
  );

  qspd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .status    (fifo_st)
  );

  assign kind       = head.kind;
  assign out_byte   = head.data;
  assign error_kind = head.error_kind;
  assign err_offset = head.err_offset;
  assign last       = head.last;

  // Checks
  `QSPD_ASSERT_NEVER(a_fifo_overflow,
    fifo_st.count > qspd_pkg::FIFO_CW'(qspd_pkg::FIFO_DEPTH), "result queue overflow")
  `QSPD_ASSERT_IMPLIES(a_error_closes_frame,
    push_n != 2'd0 && res0.kind == qspd_pkg::KIND_ERROR,
    push_n == 2'd1 && res0.last, "error result not final")
  `QSPD_ASSERT_IMPLIES(a_second_error_last,
    push_n == 2'd2 && res1.kind == qspd_pkg::KIND_ERROR, res1.last, "error result not final")
  `QSPD_ASSERT_IMPLIES(a_discard_silent,
    take && core_st.discarding, push_n == 2'd0, "results pushed while discarding")

endmodule

`default_nettype wire
